### src/nqsc_pkg.sv
// Shared constants and control types for the N-queens solution counter.
`timescale 1ns / 1ps

package nqsc_pkg;

    // Largest board the search hardware holds
    localparam int MAX_BOARD = 16;

    // Field and counter widths
    localparam int COL_W   = 4;
    localparam int SIZE_W  = 5;
    localparam int DEPTH_W = $clog2(MAX_BOARD);
    localparam int COUNT_W = 24;
    localparam int SUM_W   = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Configuration register addresses
    localparam logic [ADDR_W-1:0] ADDR_BOARD_SIZE = ADDR_W'(0);
    localparam logic [SIZE_W-1:0] BOARD_SIZE_RST  = SIZE_W'(8);

    // One bit per column of the board
    typedef logic [MAX_BOARD-1:0] t_mask;

    // Controller to datapath commands
    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic search_done;
    } t_dp_status;

endpackage

### src/nqsc_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface nqsc_in_if;
    import nqsc_pkg::*;
    logic             valid;
    logic             ready;
    logic [COL_W-1:0] first_column;

    modport source (output valid, output first_column, input ready);
    modport sink   (input valid, input first_column, output ready);
endinterface

interface nqsc_out_if;
    import nqsc_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] column_solutions;
    logic [SUM_W-1:0]   running_total;
    logic               start_invalid;

    modport source (output valid, output column_solutions, output running_total,
                    output start_invalid, input ready);
    modport sink   (input valid, input column_solutions, input running_total,
                    input start_invalid, output ready);
endinterface

### src/nqsc_cfg.sv
// APB-style configuration register block holding the board size.
`timescale 1ns / 1ps

module nqsc_cfg import nqsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output logic [DATA_W-1:0] o_prdata,
    output logic              o_pready,
    output logic [SIZE_W-1:0] o_board_size
);

    logic [SIZE_W-1:0] r_board_size;
    logic              wr_en;

    // Write completes in the access phase; no wait states
    assign wr_en = i_psel && i_penable && i_pwrite && (i_paddr == ADDR_BOARD_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_board_size <= BOARD_SIZE_RST;
        end else if (wr_en) begin
            r_board_size <= i_pwdata[SIZE_W-1:0];
        end
    end

    // Read back; other addresses read as zero
    always_comb begin
        o_prdata = '0;
        if (i_paddr == ADDR_BOARD_SIZE) begin
            o_prdata = {{(DATA_W-SIZE_W){1'b0}}, r_board_size};
        end
    end

    assign o_pready     = 1'b1;
    assign o_board_size = r_board_size;

endmodule

### src/nqsc_datapath.sv
// Backtracking search datapath: per-row masks, placement stack, counters.
`timescale 1ns / 1ps

module nqsc_datapath import nqsc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic [SIZE_W-1:0]  i_board_size,
    input  logic [COL_W-1:0]   i_first_column,
    output logic [COUNT_W-1:0] o_column_solutions,
    output logic [SUM_W-1:0]   o_running_total,
    output logic               o_start_invalid
);

    // Position of the single set bit of a one-hot mask
    function automatic logic [COL_W-1:0] bit_index(input t_mask b);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAX_BOARD; i++) begin
            if (b[i]) begin
                idx = idx | COL_W'(i);
            end
        end
        return idx;
    endfunction

    // Search state
    logic [SIZE_W-1:0]  r_size;
    t_mask              r_full;
    logic               r_invalid;
    logic [DEPTH_W-1:0] r_depth;
    t_mask              r_cols;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_invalid;

    // Per-row diagonal masks, free columns and chosen column
    t_mask              r_left  [MAX_BOARD];
    t_mask              r_right [MAX_BOARD];
    t_mask              r_avail [MAX_BOARD];
    logic [COL_W-1:0]   r_stack [MAX_BOARD];

    // Request setup
    logic [SIZE_W-1:0]  size_eff;
    t_mask              full_start;
    t_mask              first;
    logic               start_invalid;
    logic               single;

    // Step logic
    t_mask              cur_av;
    t_mask              low_bit;
    logic               leaf;
    t_mask              next_cols;
    t_mask              next_left;
    t_mask              next_right;
    t_mask              next_avail;
    logic [COL_W-1:0]   back_col;
    logic [DEPTH_W-1:0] depth_up;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_next;

    // Clamp the board size and build the first-row masks
    always_comb begin
        size_eff = (i_board_size > SIZE_W'(MAX_BOARD)) ? SIZE_W'(MAX_BOARD) : i_board_size;
        for (int i = 0; i < MAX_BOARD; i++) begin
            full_start[i] = (SIZE_W'(i) < size_eff);
        end
        first         = t_mask'(1) << i_first_column;
        start_invalid = ({1'b0, i_first_column} >= size_eff);
        single        = (size_eff == SIZE_W'(1));
    end

    // Take the lowest free column of the current row and derive the next row
    always_comb begin
        cur_av     = r_avail[r_depth];
        low_bit    = cur_av & (~cur_av + t_mask'(1));
        leaf       = ({1'b0, r_depth} == (r_size - SIZE_W'(1)));
        next_cols  = r_cols | low_bit;
        next_left  = ((r_left[r_depth] | low_bit) << 1) & r_full;
        next_right = (r_right[r_depth] | low_bit) >> 1;
        next_avail = r_full & ~(next_cols | next_left | next_right);
        back_col   = r_stack[r_depth - DEPTH_W'(1)];
        depth_up   = r_depth + DEPTH_W'(1);
    end

    // Saturating running total
    always_comb begin
        sum_wide = {1'b0, r_sum} + (SUM_W+1)'(r_count);
        sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    end

    // Control state: search depth and running total
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_sum   <= '0;
        end else begin
            if (i_cmd.start) begin
                r_depth <= (start_invalid || single) ? '0 : DEPTH_W'(1);
            end else if (i_cmd.step) begin
                if (cur_av == '0) begin
                    r_depth <= r_depth - DEPTH_W'(1);
                end else if (!leaf) begin
                    r_depth <= depth_up;
                end
            end
            if (i_cmd.finish) begin
                r_sum <= sum_next;
            end
        end
    end

    // Search payload: masks, stack, count, output hold
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_size                 <= size_eff;
            r_full                 <= full_start;
            r_invalid              <= start_invalid;
            r_count                <= (single && !start_invalid) ? COUNT_W'(1) : '0;
            r_cols                 <= first;
            r_stack[0]             <= i_first_column;
            r_left[DEPTH_W'(1)]    <= (first << 1) & full_start;
            r_right[DEPTH_W'(1)]   <= first >> 1;
            r_avail[DEPTH_W'(1)]   <= full_start & ~(first | (first << 1) | (first >> 1));
        end else if (i_cmd.step) begin
            if (cur_av == '0) begin
                // Row exhausted: lift the queen of the row above
                r_cols <= r_cols ^ (t_mask'(1) << back_col);
            end else begin
                r_avail[r_depth] <= cur_av ^ low_bit;
                r_stack[r_depth] <= bit_index(low_bit);
                if (leaf) begin
                    if (r_count != {COUNT_W{1'b1}}) begin
                        r_count <= r_count + COUNT_W'(1);
                    end
                end else begin
                    r_cols            <= next_cols;
                    r_left[depth_up]  <= next_left;
                    r_right[depth_up] <= next_right;
                    r_avail[depth_up] <= next_avail;
                end
            end
        end
        if (i_cmd.finish) begin
            r_out_count   <= r_count;
            r_out_invalid <= r_invalid;
        end
    end

    assign o_status.search_done = (r_depth == '0);
    assign o_column_solutions   = r_out_count;
    assign o_running_total      = r_sum;
    assign o_start_invalid      = r_out_invalid;

endmodule

### src/nqsc_ctrl.sv
// Controller state machine sequencing request intake, search and result transfer.
`timescale 1ns / 1ps

module nqsc_ctrl import nqsc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_status.search_done) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_FINISH: begin
                // Load the result once the output register is free
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### src/n_queens_solution_counter.sv
// Top level of the N-queens solution counter.
`timescale 1ns / 1ps

// Counts placements of board_size non-attacking queens given the column of
// the first-row queen, and keeps a saturating total over all requests. One
// request is worked at a time by a depth-first search that spends one clock
// per search step (one candidate placed or one row backed out of). Invalid
// starts and a 1x1 board finish without any search step. A new request
// is taken while the previous result still waits in the output register.
// The board size (reset 8, values above 16 treated as 16) sits at byte
// address 0 and must only be written while the block is idle.
module n_queens_solution_counter import nqsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nqsc_in_if.sink           i_req,
    nqsc_out_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [SIZE_W-1:0] board_size;
    t_dp_cmd           dp_cmd;
    t_dp_status        dp_status;

    // Configuration register
    nqsc_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_prdata     (prdata),
        .o_pready     (pready),
        .o_board_size (board_size)
    );

    // Sequencer
    nqsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (dp_cmd),
        .i_status    (dp_status)
    );

    // Search engine and result registers
    nqsc_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_status           (dp_status),
        .i_board_size       (board_size),
        .i_first_column     (i_req.first_column),
        .o_column_solutions (o_rsp.column_solutions),
        .o_running_total    (o_rsp.running_total),
        .o_start_invalid    (o_rsp.start_invalid)
    );

endmodule
